/* rtl/gcw_pkg.sv */
`default_nettype none

package gcw_pkg;

    localparam logic [6:0]  WINDOW_SIZE_RST = 7'd32;
    localparam logic [31:0] Q31_ONE         = 32'h8000_0000;
    localparam logic [31:0] T_LIMIT         = 32'h4000_0000;
    localparam logic [22:0] SCALE_Q24       = 23'd6693141;
    localparam logic [31:0] SAT_VALUE       = 32'hFFFF_FFFF;
    localparam logic [5:0]  KDIV_STEPS      = 6'd31;
    localparam logic [5:0]  FDIV_STEPS      = 6'd32;
    localparam logic [2:0]  HORNER_FIRST_K  = 3'd6;
    localparam logic [2:0]  SQUARE_LAST     = 3'd4;

    // register index decoded from paddr[2]
    localparam logic        REG_WINDOW_SIZE = 1'b0;

    // commands from the sequencer, one per state
    typedef struct packed {
        logic idle;
        logic rd;
        logic diff;
        logic chk;
        logic kdiv;
        logic h1;
        logic h2;
        logic h3;
        logic sq;
        logic acc;
        logic sc1;
        logic sc2;
        logic schk;
        logic fdiv;
        logic out;
    } t_cmd;

    // status back to the sequencer
    typedef struct packed {
        logic final_smp;
        logic pre_zero;
        logic div_done;
        logic t_big;
        logic k_last;
        logic sq_last;
        logic pair_last;
        logic fin_sat;
        logic out_free;
    } t_sts;

    // floor(2^32 / k), with all ones standing in for k = 1
    function automatic logic [31:0] recip(input logic [2:0] k);
        logic [31:0] r;
        unique case (k)
            3'd1:    r = 32'hFFFF_FFFF;
            3'd2:    r = 32'h8000_0000;
            3'd3:    r = 32'h5555_5555;
            3'd4:    r = 32'h4000_0000;
            3'd5:    r = 32'h3333_3333;
            3'd6:    r = 32'h2AAA_AAAA;
            default: r = 32'h0000_0000;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/gcw_div.sv */
`default_nettype none

// restoring divider, one quotient bit per cycle
module gcw_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_rem0,
    input  wire logic [31:0] i_den,
    input  wire logic [31:0] i_num,
    input  wire logic [5:0]  i_steps,
    output logic             o_done,
    output logic [31:0]      o_quot
);

    logic [31:0] r_rem, n_rem;
    logic [31:0] r_den;
    logic [31:0] r_num;
    logic [31:0] r_quot;
    logic [5:0]  r_cnt;
    logic        r_done;
    logic [32:0] sh;
    logic [32:0] diff;
    logic        ge;

    always_comb begin
        sh    = {r_rem, r_num[31]};
        diff  = sh - {1'b0, r_den};
        ge    = (sh >= {1'b0, r_den});
        n_rem = ge ? diff[31:0] : sh[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= i_steps;
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - 6'd1;
            r_done <= (r_cnt == 6'd1);
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_rem0;
            r_den  <= i_den;
            r_num  <= i_num;
            r_quot <= '0;
        end else if (r_cnt != '0) begin
            r_rem  <= n_rem;
            r_num  <= {r_num[30:0], 1'b0};
            r_quot <= {r_quot[30:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

/* rtl/gcw_datapath.sv */
`default_nettype none

module gcw_datapath #(
    parameter int MAX_WINDOW = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire gcw_pkg::t_cmd i_cmd,
    output gcw_pkg::t_sts      o_sts,
    input  wire logic          i_cfg_we,
    input  wire logic [6:0]    i_cfg_data,
    output logic [6:0]         o_window_size,
    input  wire logic          i_s_valid,
    input  wire logic [15:0]   i_sample,
    input  wire logic [15:0]   i_sigma,
    input  wire logic          i_m_ready,
    output logic               o_m_valid,
    output logic [31:0]        o_m_data,
    output logic               o_m_sat
);

    localparam int DEPTH = 2 * MAX_WINDOW;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    logic [15:0]   mem [DEPTH];

    logic [6:0]    r_ws;
    logic [CW-1:0] r_fill;
    logic [CW-1:0] r_i, r_j;
    logic [39:0]   r_sum;
    logic [15:0]   r_sig;
    logic [31:0]   r_s2;
    logic [15:0]   r_xa, r_xb;
    logic [31:0]   r_d2;
    logic [30:0]   r_t;
    logic [31:0]   r_q;
    logic [2:0]    r_k;
    logic [2:0]    r_n;
    logic          r_zero;
    logic [62:0]   r_prod;
    logic [62:0]   r_est;
    logic [42:0]   r_pp;
    logic [62:0]   r_num;
    logic [31:0]   r_res;
    logic          r_rsat;
    logic          r_mvalid;
    logic [31:0]   r_mdata;
    logic          r_msat;

    logic [CW-1:0] w_eff;
    logic [CW:0]   two_w;
    logic [CW:0]   fill_nx;
    logic          accept;
    logic          final_smp;
    logic [AW-1:0] addr_b;
    logic [16:0]   d;
    logic [16:0]   ad;
    logic          pre_zero;
    logic [30:0]   p;
    logic [30:0]   qe;
    logic [33:0]   qk;
    logic [33:0]   rem;
    logic [30:0]   hq;
    logic [63:0]   y2;
    logic [31:0]   tsum;
    logic [24:0]   term;
    logic [42:0]   pp_hi;
    logic [13:0]   nh;
    logic          fin_sat;
    logic          pair_last;
    logic          out_free;

    logic          div_start;
    logic [31:0]   div_rem0, div_den, div_num;
    logic [5:0]    div_steps;
    logic          div_done;
    logic [31:0]   div_quot;

    // effective window: zero reads as one, clamp at MAX_WINDOW
    always_comb begin
        if (r_ws == 7'd0) begin
            w_eff = CW'(1);
        end else if (32'(r_ws) > 32'(MAX_WINDOW)) begin
            w_eff = CW'(MAX_WINDOW);
        end else begin
            w_eff = CW'(r_ws);
        end
    end

    assign two_w     = {w_eff, 1'b0};
    assign fill_nx   = {1'b0, r_fill} + (CW+1)'(1);
    assign accept    = i_cmd.idle && i_s_valid;
    assign final_smp = (fill_nx == two_w);
    assign addr_b    = r_i[AW-1:0] + r_j[AW-1:0];

    assign d        = {r_xa[15], r_xa} - {r_xb[15], r_xb};
    assign ad       = d[16] ? (17'd0 - d) : d;
    assign pre_zero = ({6'b0, r_d2} >= {r_s2, 6'b0});

    // horner step: p = t*q >> 31, then p / k by reciprocal and one fix-up
    assign p    = r_prod[61:31];
    assign qe   = r_est[62:32];
    assign qk   = {3'b0, qe} * {31'b0, r_k};
    assign rem  = {3'b0, p} - qk;
    assign hq   = (rem >= {31'b0, r_k}) ? (qe + 31'd1) : qe;

    assign y2   = r_q * r_q;
    assign tsum = r_q + 32'd64;
    assign term = tsum[31:7];

    assign pp_hi   = r_sum[39:20] * gcw_pkg::SCALE_Q24;
    assign nh      = r_num[62:49];
    assign fin_sat = ({2'b0, nh} >= r_sig);

    assign pair_last = (r_i == (w_eff - CW'(1))) && (r_j == w_eff);
    assign out_free  = !r_mvalid || i_m_ready;

    // shared divider: kernel exponent t, then the final scale
    assign div_start = (i_cmd.chk && !pre_zero) || (i_cmd.schk && !fin_sat);
    always_comb begin
        if (i_cmd.chk) begin
            div_rem0  = {6'b0, r_d2[31:6]};
            div_den   = r_s2;
            div_num   = {r_d2[5:0], 26'b0};
            div_steps = gcw_pkg::KDIV_STEPS;
        end else begin
            div_rem0  = {18'b0, nh};
            div_den   = {16'b0, r_sig};
            div_num   = r_num[48:17];
            div_steps = gcw_pkg::FDIV_STEPS;
        end
    end

    gcw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_rem0  (div_rem0),
        .i_den   (div_den),
        .i_num   (div_num),
        .i_steps (div_steps),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // sample store
    always_ff @(posedge i_clk) begin
        if (accept) begin
            mem[r_fill[AW-1:0]] <= i_sample;
        end
        if (i_cmd.rd) begin
            r_xa <= mem[r_i[AW-1:0]];
            r_xb <= mem[addr_b];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws     <= gcw_pkg::WINDOW_SIZE_RST;
            r_fill   <= '0;
            r_sum    <= '0;
            r_mvalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_ws   <= i_cfg_data;
                r_fill <= '0;
                r_sum  <= '0;
            end else if (accept) begin
                if (final_smp) begin
                    r_fill <= '0;
                    r_sum  <= '0;
                end else begin
                    r_fill <= fill_nx[CW-1:0];
                end
            end else if (i_cmd.acc) begin
                r_sum <= r_sum + (r_zero ? 40'd0 : {15'b0, term});
            end
            if (i_cmd.out && out_free) begin
                r_mvalid <= 1'b1;
            end else if (i_m_ready) begin
                r_mvalid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_s2 <= r_sig * r_sig;
        if (accept && final_smp) begin
            r_sig <= (i_sigma == 16'd0) ? 16'd1 : i_sigma;
            r_i   <= '0;
            r_j   <= CW'(1);
        end
        if (i_cmd.diff) begin
            r_d2 <= ad[15:0] * ad[15:0];
        end
        if (i_cmd.chk && pre_zero) begin
            r_zero <= 1'b1;
        end
        if (i_cmd.kdiv && div_done) begin
            r_t    <= div_quot[30:0];
            r_q    <= gcw_pkg::Q31_ONE;
            r_k    <= gcw_pkg::HORNER_FIRST_K;
            r_n    <= '0;
            r_zero <= (div_quot > gcw_pkg::T_LIMIT);
        end
        if (i_cmd.h1) begin
            r_prod <= r_t * r_q;
        end
        if (i_cmd.h2) begin
            r_est <= p * gcw_pkg::recip(r_k);
        end
        if (i_cmd.h3) begin
            r_q <= gcw_pkg::Q31_ONE - {1'b0, hq};
            r_k <= r_k - 3'd1;
        end
        if (i_cmd.sq) begin
            r_q <= y2[62:31] + {31'b0, y2[30]};
            r_n <= r_n + 3'd1;
        end
        if (i_cmd.acc) begin
            if (r_j == w_eff) begin
                r_j <= CW'(1);
                r_i <= r_i + CW'(1);
            end else begin
                r_j <= r_j + CW'(1);
            end
        end
        if (i_cmd.sc1) begin
            r_pp <= r_sum[19:0] * gcw_pkg::SCALE_Q24;
        end
        if (i_cmd.sc2) begin
            r_num <= {pp_hi, 20'b0} + {20'b0, r_pp};
        end
        if (i_cmd.schk && fin_sat) begin
            r_res  <= gcw_pkg::SAT_VALUE;
            r_rsat <= 1'b1;
        end
        if (i_cmd.fdiv && div_done) begin
            r_res  <= div_quot;
            r_rsat <= 1'b0;
        end
        if (i_cmd.out && out_free) begin
            r_mdata <= r_res;
            r_msat  <= r_rsat;
        end
    end

    always_comb begin
        o_sts.final_smp = final_smp;
        o_sts.pre_zero  = pre_zero;
        o_sts.div_done  = div_done;
        o_sts.t_big     = (div_quot > gcw_pkg::T_LIMIT);
        o_sts.k_last    = (r_k == 3'd1);
        o_sts.sq_last   = (r_n == gcw_pkg::SQUARE_LAST);
        o_sts.pair_last = pair_last;
        o_sts.fin_sat   = fin_sat;
        o_sts.out_free  = out_free;
    end

    assign o_window_size = r_ws;
    assign o_m_valid     = r_mvalid;
    assign o_m_data      = r_mdata;
    assign o_m_sat       = r_msat;

endmodule

`default_nettype wire

/* rtl/gcw_ctrl.sv */
`default_nettype none

module gcw_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_valid,
    input  wire gcw_pkg::t_sts i_sts,
    output gcw_pkg::t_cmd      o_cmd
);

    typedef enum logic [14:0] {
        S_IDLE = 15'b000000000000001,
        S_READ = 15'b000000000000010,
        S_DIFF = 15'b000000000000100,
        S_CHK  = 15'b000000000001000,
        S_KDIV = 15'b000000000010000,
        S_H1   = 15'b000000000100000,
        S_H2   = 15'b000000001000000,
        S_H3   = 15'b000000010000000,
        S_SQ   = 15'b000000100000000,
        S_ACC  = 15'b000001000000000,
        S_SC1  = 15'b000010000000000,
        S_SC2  = 15'b000100000000000,
        S_SCHK = 15'b001000000000000,
        S_FDIV = 15'b010000000000000,
        S_OUT  = 15'b100000000000000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_valid && i_sts.final_smp) n_state = S_READ;
            end
            S_READ: n_state = S_DIFF;
            S_DIFF: n_state = S_CHK;
            S_CHK:  n_state = i_sts.pre_zero ? S_ACC : S_KDIV;
            S_KDIV: begin
                if (i_sts.div_done) n_state = i_sts.t_big ? S_ACC : S_H1;
            end
            S_H1:   n_state = S_H2;
            S_H2:   n_state = S_H3;
            S_H3:   n_state = i_sts.k_last ? S_SQ : S_H1;
            S_SQ:   begin
                if (i_sts.sq_last) n_state = S_ACC;
            end
            S_ACC:  n_state = i_sts.pair_last ? S_SC1 : S_READ;
            S_SC1:  n_state = S_SC2;
            S_SC2:  n_state = S_SCHK;
            S_SCHK: n_state = i_sts.fin_sat ? S_OUT : S_FDIV;
            S_FDIV: begin
                if (i_sts.div_done) n_state = S_OUT;
            end
            S_OUT:  begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd.idle = (r_state == S_IDLE);
        o_cmd.rd   = (r_state == S_READ);
        o_cmd.diff = (r_state == S_DIFF);
        o_cmd.chk  = (r_state == S_CHK);
        o_cmd.kdiv = (r_state == S_KDIV);
        o_cmd.h1   = (r_state == S_H1);
        o_cmd.h2   = (r_state == S_H2);
        o_cmd.h3   = (r_state == S_H3);
        o_cmd.sq   = (r_state == S_SQ);
        o_cmd.acc  = (r_state == S_ACC);
        o_cmd.sc1  = (r_state == S_SC1);
        o_cmd.sc2  = (r_state == S_SC2);
        o_cmd.schk = (r_state == S_SCHK);
        o_cmd.fdiv = (r_state == S_FDIV);
        o_cmd.out  = (r_state == S_OUT);
    end

endmodule

`default_nettype wire

/* rtl/gaussian_correntropy_window_top.sv */
// sequence: a non-final word is only stored; the final word of a window starts
//   W*W kernel terms: each ends early when the term vanishes, after the shared divider
//   when the exponent is out of range, else after divider, horner and 5 squarings,
//   then the scaling with its own divide, which is skipped when the result saturates
// throughput: one word per cycle while a window fills, no words taken during the sum
// reset: synchronous active low; window size 32, empty window, output empty
`default_nettype none

module gaussian_correntropy_window_top #(
    parameter int MAX_WINDOW = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // apb configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // input words
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [15:0] sample, [31:16] sigma
    // result words
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] correntropy
    output logic [0:0]       m_axis_tuser    // [0] saturated
);

    gcw_pkg::t_cmd cmd;
    gcw_pkg::t_sts sts;
    logic          cfg_we;
    logic [6:0]    window_size;

    // register write lands on the access cycle
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == gcw_pkg::REG_WINDOW_SIZE);
    assign prdata = (paddr[2] == gcw_pkg::REG_WINDOW_SIZE) ? {25'b0, window_size} : 32'd0;

    // words are taken only while the sequencer idles
    assign s_axis_tready = cmd.idle;

    gcw_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    gcw_datapath #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_we      (cfg_we),
        .i_cfg_data    (pwdata[6:0]),
        .o_window_size (window_size),
        .i_s_valid     (s_axis_tvalid),
        .i_sample      (s_axis_tdata[15:0]),
        .i_sigma       (s_axis_tdata[31:16]),
        .i_m_ready     (m_axis_tready),
        .o_m_valid     (m_axis_tvalid),
        .o_m_data      (m_axis_tdata),
        .o_m_sat       (m_axis_tuser[0])
    );

endmodule

`default_nettype wire

/* rtl/gcw_checker.sv */
`default_nettype none

module gcw_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        pready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic [0:0]  m_axis_tuser
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // saturation flag only with the clipped value
    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 32'hFFFF_FFFF)
        else $error("saturated flag without clipped value");

    // reset empties the output stage
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // no wait states on the register port
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind gaussian_correntropy_window_top gcw_checker u_gcw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .pready        (pready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
